// ===== src/htd_pkg.sv =====
// htd_pkg: shared constants, types and state codes for the huffman tree decoder
// used by htd_front, htd_back, huffman_tree_decoder and htd_checker
// depends on nothing
package htd_pkg;

	localparam int MAX_NODES    = 512;
	localparam int MAX_CODE_LEN = 32;
	localparam int NODE_W       = $clog2(MAX_NODES);
	localparam int CNT_W        = $clog2(MAX_NODES + 1);
	localparam int SYM_W        = 8;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int BIDX_W       = $clog2(CODE_W);
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic {
		KIND_LOAD = 1'b0,
		KIND_BIT  = 1'b1
	} kind_t;

	typedef enum logic {
		STATUS_OK      = 1'b0,
		STATUS_MISSING = 1'b1
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [SYM_W-1:0]  symbol;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
		logic              msg_bit;
	} item_t;

	typedef struct packed {
		logic              valid;
		item_t             item;
	} queue_head_t;

	typedef struct packed {
		logic [NODE_W-1:0] left;
		logic [NODE_W-1:0] right;
		logic [SYM_W-1:0]  sym;
	} node_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_WALK,
		S_ALLOC,
		S_BIT_CUR,
		S_BIT_NEXT
	} state_t;

endpackage

// ===== src/htd_front.sv =====
// htd_front: request intake, classification and a short request queue
// drops overlong code loads before they reach the back end
// depends on htd_pkg
module htd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [htd_pkg::SYM_W-1:0]   symbol,
	input  logic [htd_pkg::CODE_W-1:0]  code_bits,
	input  logic [htd_pkg::LEN_W-1:0]   code_length,
	input  logic                        message_bit,
	output htd_pkg::queue_head_t        head,
	input  logic                        pop
);

	htd_pkg::item_t             entry_q [htd_pkg::QUEUE_DEPTH];
	logic [htd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [htd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [htd_pkg::QCNT_W-1:0] count_q;
	logic                       accept;
	logic                       keep;
	logic                       push;
	logic                       do_pop;
	htd_pkg::item_t             new_item;

	assign in_stall = (count_q == htd_pkg::QCNT_W'(htd_pkg::QUEUE_DEPTH));
	assign accept   = in_valid && !in_stall;

	always_comb begin
		new_item.kind    = htd_pkg::kind_t'(kind);
		new_item.symbol  = symbol;
		new_item.code    = code_bits;
		new_item.len     = code_length;
		new_item.msg_bit = message_bit;
	end

	// overlong loads leave the table untouched
	assign keep   = (new_item.kind == htd_pkg::KIND_BIT) ||
		(code_length <= htd_pkg::LEN_W'(htd_pkg::MAX_CODE_LEN));
	assign push   = accept && keep;
	assign do_pop = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + htd_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == htd_pkg::QPTR_W'(htd_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + htd_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + htd_pkg::QCNT_W'(1);
			end else if (!push && do_pop) begin
				count_q <= count_q - htd_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= new_item;
		end
	end

endmodule

// ===== src/htd_back.sv =====
// htd_back: node table, code insertion walk and bit-by-bit decode walk
// holds the node memory, the root node registers and the result register
// depends on htd_pkg
module htd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  htd_pkg::queue_head_t       head,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [htd_pkg::SYM_W-1:0]  decoded_symbol,
	output logic                       status
);

	htd_pkg::node_t mem [htd_pkg::MAX_NODES];

	htd_pkg::state_t             state_q;
	htd_pkg::state_t             state_d;
	htd_pkg::item_t              item_q;
	htd_pkg::node_t              rd_q;
	htd_pkg::node_t              root_q;
	logic [htd_pkg::NODE_W-1:0]  node_q;
	logic [htd_pkg::NODE_W-1:0]  node_d;
	logic [htd_pkg::LEN_W-1:0]   idx_q;
	logic [htd_pkg::LEN_W-1:0]   idx_d;
	logic [htd_pkg::NODE_W-1:0]  new_q;
	logic [htd_pkg::NODE_W-1:0]  new_d;
	logic [htd_pkg::NODE_W-1:0]  nxt_q;
	logic [htd_pkg::NODE_W-1:0]  nxt_d;
	logic [htd_pkg::NODE_W-1:0]  cur_q;
	logic [htd_pkg::NODE_W-1:0]  cur_d;
	logic [htd_pkg::CNT_W-1:0]   used_q;
	logic [htd_pkg::CNT_W-1:0]   used_d;
	logic                        out_valid_q;
	logic [htd_pkg::SYM_W-1:0]   out_sym_q;
	htd_pkg::status_t            out_status_q;

	htd_pkg::node_t              walk_w;
	htd_pkg::node_t              cur_w;
	logic [htd_pkg::BIDX_W-1:0]  pos;
	logic                        code_b;
	logic [htd_pkg::NODE_W-1:0]  walk_child;
	logic                        walk_done;
	logic [htd_pkg::CNT_W:0]     need;
	logic                        fits;
	logic [htd_pkg::NODE_W-1:0]  bit_child;
	logic                        is_inner;
	logic                        out_free;

	logic                        wr_en;
	logic [htd_pkg::NODE_W-1:0]  wr_addr;
	htd_pkg::node_t              wr_data;
	logic [htd_pkg::NODE_W-1:0]  rd_addr;
	logic                        emit;
	logic [htd_pkg::SYM_W-1:0]   emit_sym;
	htd_pkg::status_t            emit_status;

	// datapath shared by both walks
	always_comb begin
		walk_w     = (node_q == '0) ? root_q : rd_q;
		cur_w      = (cur_q == '0) ? root_q : rd_q;
		pos        = htd_pkg::BIDX_W'(item_q.len - htd_pkg::LEN_W'(1) - idx_q);
		code_b     = item_q.code[pos];
		walk_child = code_b ? walk_w.right : walk_w.left;
		walk_done  = (idx_q == item_q.len);
		need       = {1'b0, used_q} + (htd_pkg::CNT_W + 1)'(item_q.len - idx_q);
		fits       = (need <= (htd_pkg::CNT_W + 1)'(htd_pkg::MAX_NODES));
		bit_child  = item_q.msg_bit ? cur_w.right : cur_w.left;
		is_inner   = (rd_q.left != '0) || (rd_q.right != '0);
		out_free   = !out_valid_q || !out_stall;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			htd_pkg::S_IDLE: begin
				if (head.valid) begin
					state_d = (head.item.kind == htd_pkg::KIND_BIT) ?
						htd_pkg::S_BIT_CUR : htd_pkg::S_WALK;
				end
			end
			htd_pkg::S_WALK: begin
				if (walk_done) begin
					state_d = htd_pkg::S_IDLE;
				end else if (walk_child == '0) begin
					state_d = fits ? htd_pkg::S_ALLOC : htd_pkg::S_IDLE;
				end
			end
			htd_pkg::S_ALLOC: begin
				if (walk_done) begin
					state_d = htd_pkg::S_IDLE;
				end
			end
			htd_pkg::S_BIT_CUR: begin
				if (bit_child != '0) begin
					state_d = htd_pkg::S_BIT_NEXT;
				end else if (out_free) begin
					state_d = htd_pkg::S_IDLE;
				end
			end
			htd_pkg::S_BIT_NEXT: begin
				if (is_inner || out_free) begin
					state_d = htd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = htd_pkg::S_IDLE;
			end
		endcase
	end

	// outputs and register updates
	always_comb begin
		pop         = 1'b0;
		rd_addr     = cur_q;
		wr_en       = 1'b0;
		wr_addr     = node_q;
		wr_data     = walk_w;
		emit        = 1'b0;
		emit_sym    = '0;
		emit_status = htd_pkg::STATUS_OK;
		node_d      = node_q;
		idx_d       = idx_q;
		new_d       = new_q;
		nxt_d       = nxt_q;
		cur_d       = cur_q;
		used_d      = used_q;
		unique case (state_q)
			htd_pkg::S_IDLE: begin
				pop    = head.valid;
				node_d = '0;
				idx_d  = '0;
			end
			htd_pkg::S_WALK: begin
				if (walk_done) begin
					wr_en       = 1'b1;
					wr_data.sym = item_q.symbol;
				end else if (walk_child != '0) begin
					node_d  = walk_child;
					idx_d   = idx_q + htd_pkg::LEN_W'(1);
					rd_addr = walk_child;
				end else if (fits) begin
					// link the first new node under the deepest existing one
					wr_en = 1'b1;
					if (code_b) begin
						wr_data.right = used_q[htd_pkg::NODE_W-1:0];
					end else begin
						wr_data.left = used_q[htd_pkg::NODE_W-1:0];
					end
					new_d = used_q[htd_pkg::NODE_W-1:0];
					idx_d = idx_q + htd_pkg::LEN_W'(1);
				end
			end
			htd_pkg::S_ALLOC: begin
				wr_en   = 1'b1;
				wr_addr = new_q;
				if (walk_done) begin
					wr_data.left  = '0;
					wr_data.right = '0;
					wr_data.sym   = item_q.symbol;
					used_d        = htd_pkg::CNT_W'(new_q) + htd_pkg::CNT_W'(1);
				end else begin
					wr_data.left  = code_b ? '0 : new_q + htd_pkg::NODE_W'(1);
					wr_data.right = code_b ? new_q + htd_pkg::NODE_W'(1) : '0;
					wr_data.sym   = '0;
					new_d         = new_q + htd_pkg::NODE_W'(1);
					idx_d         = idx_q + htd_pkg::LEN_W'(1);
				end
			end
			htd_pkg::S_BIT_CUR: begin
				if (bit_child != '0) begin
					nxt_d   = bit_child;
					rd_addr = bit_child;
				end else if (out_free) begin
					emit        = 1'b1;
					emit_status = htd_pkg::STATUS_MISSING;
					cur_d       = '0;
				end
			end
			htd_pkg::S_BIT_NEXT: begin
				rd_addr = nxt_q;
				if (is_inner) begin
					cur_d = nxt_q;
				end else if (out_free) begin
					emit     = 1'b1;
					emit_sym = rd_q.sym;
					cur_d    = '0;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= htd_pkg::S_IDLE;
			cur_q       <= '0;
			used_q      <= htd_pkg::CNT_W'(1);
			out_valid_q <= 1'b0;
			root_q      <= '0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
			used_q  <= used_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en && (wr_addr == '0)) begin
				root_q <= wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		idx_q  <= idx_d;
		new_q  <= new_d;
		nxt_q  <= nxt_d;
		if (pop) begin
			item_q <= head.item;
		end
		if (emit) begin
			out_sym_q    <= emit_sym;
			out_status_q <= emit_status;
		end
	end

	// node table, entry zero lives in root_q
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr != '0)) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign out_valid      = out_valid_q;
	assign decoded_symbol = out_sym_q;
	assign status         = out_status_q;

endmodule

// ===== src/huffman_tree_decoder.sv =====
// huffman_tree_decoder: a message bit uses S_BIT_CUR, and S_BIT_NEXT too when a child exists
// a load holds the back end for one node read or write per level of the code
// out_valid rises from S_BIT_CUR (missing child) or S_BIT_NEXT (leaf) once the output is free
// a two-entry request queue lets intake run ahead of the tree walk
// reset clears control, the root node and the node count; the node memory is not swept,
// since every node is written when it is allocated
module huffman_tree_decoder (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [htd_pkg::SYM_W-1:0]  symbol,
	input  logic [htd_pkg::CODE_W-1:0] code_bits,
	input  logic [htd_pkg::LEN_W-1:0]  code_length,
	input  logic                       message_bit,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [htd_pkg::SYM_W-1:0]  decoded_symbol,
	output logic                       status
);

	htd_pkg::queue_head_t head;
	logic                 pop;

	htd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_length (code_length),
		.message_bit (message_bit),
		.head        (head),
		.pop         (pop)
	);

	htd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.decoded_symbol (decoded_symbol),
		.status         (status)
	);

endmodule

// ===== src/htd_checker.sv =====
// htd_checker: port-level checks for huffman_tree_decoder, bound to the top level
// depends on htd_pkg
module htd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       kind,
	input logic [htd_pkg::SYM_W-1:0]  symbol,
	input logic [htd_pkg::CODE_W-1:0] code_bits,
	input logic [htd_pkg::LEN_W-1:0]  code_length,
	input logic                       message_bit,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [htd_pkg::SYM_W-1:0]  decoded_symbol,
	input logic                       status
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(decoded_symbol) && $stable(status))
		else $error("result changed while stalled");

	// a stalled request keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(kind) && $stable(symbol) &&
			$stable(code_bits) && $stable(code_length) && $stable(message_bit))
		else $error("request changed while stalled");

	// a missing child reports symbol zero
	a_missing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == htd_pkg::STATUS_MISSING) |-> decoded_symbol == '0)
		else $error("missing child with nonzero symbol");

	// the queue fills only through an accepted request
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall))
		else $error("stall rose without an accepted request");

	// leaving reset the block is empty
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !in_stall && !out_valid)
		else $error("not empty after reset");

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);
